/* src/kaf_pkg.sv */
// Package for the angle and gyro-bias Kalman filter.
// Holds formats, ALU operation codes, operand codes, sequencer states and the micro-program.
// No dependencies.
`default_nettype none
package kaf_pkg;

  localparam int DATA_W   = 32;
  localparam int COV_FRAC = 30;
  localparam int DT_FRAC  = 20;
  localparam int CFG_W    = 30;
  localparam int DT_W     = 24;
  localparam int IDX_W    = 2;
  localparam int NSTEPS   = 29;
  localparam int STEP_W   = $clog2(NSTEPS);

  localparam logic [IDX_W-1:0] REG_Q_ANGLE    = 2'd0;
  localparam logic [IDX_W-1:0] REG_Q_BIAS     = 2'd1;
  localparam logic [IDX_W-1:0] REG_MEAS_NOISE = 2'd2;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL20,
    OP_MUL30,
    OP_DIV
  } op_t;

  typedef enum logic [4:0] {
    R_ANGLE, R_BIAS, R_P0, R_P1, R_P2, R_P3,
    R_T, R_DP, R_TMP, R_S, R_K0, R_K1, R_Y,
    R_MEAS, R_GYRO, R_DT, R_QA, R_QB, R_RM
  } opnd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_req_t;

  typedef struct packed {
    op_t   op;
    opnd_t a;
    opnd_t b;
    opnd_t dst;
  } uop_t;

  // One filter update as a sequence of two-operand operations on the shared unit.
  function automatic uop_t uop_rom(input logic [STEP_W-1:0] step);
    uop_t u;
    u = '{OP_ADD, R_ANGLE, R_T, R_ANGLE};
    unique case (step)
      5'd0:  u = '{OP_SUB,   R_GYRO,  R_BIAS,  R_TMP};
      5'd1:  u = '{OP_MUL20, R_DT,    R_TMP,   R_T};
      5'd2:  u = '{OP_ADD,   R_ANGLE, R_T,     R_ANGLE};
      5'd3:  u = '{OP_MUL20, R_DT,    R_P3,    R_DP};
      5'd4:  u = '{OP_SUB,   R_DP,    R_P1,    R_TMP};
      5'd5:  u = '{OP_SUB,   R_TMP,   R_P2,    R_TMP};
      5'd6:  u = '{OP_ADD,   R_TMP,   R_QA,    R_TMP};
      5'd7:  u = '{OP_MUL20, R_DT,    R_TMP,   R_T};
      5'd8:  u = '{OP_ADD,   R_P0,    R_T,     R_P0};
      5'd9:  u = '{OP_SUB,   R_P1,    R_DP,    R_P1};
      5'd10: u = '{OP_SUB,   R_P2,    R_DP,    R_P2};
      5'd11: u = '{OP_MUL20, R_QB,    R_DT,    R_T};
      5'd12: u = '{OP_ADD,   R_P3,    R_T,     R_P3};
      5'd13: u = '{OP_ADD,   R_P0,    R_RM,    R_S};
      5'd14: u = '{OP_DIV,   R_P0,    R_S,     R_K0};
      5'd15: u = '{OP_DIV,   R_P2,    R_S,     R_K1};
      5'd16: u = '{OP_SUB,   R_MEAS,  R_ANGLE, R_Y};
      5'd17: u = '{OP_MUL30, R_K0,    R_Y,     R_T};
      5'd18: u = '{OP_ADD,   R_ANGLE, R_T,     R_ANGLE};
      5'd19: u = '{OP_MUL30, R_K1,    R_Y,     R_T};
      5'd20: u = '{OP_ADD,   R_BIAS,  R_T,     R_BIAS};
      5'd21: u = '{OP_MUL30, R_K1,    R_P0,    R_T};
      5'd22: u = '{OP_SUB,   R_P2,    R_T,     R_P2};
      5'd23: u = '{OP_MUL30, R_K1,    R_P1,    R_T};
      5'd24: u = '{OP_SUB,   R_P3,    R_T,     R_P3};
      5'd25: u = '{OP_MUL30, R_K0,    R_P0,    R_T};
      5'd26: u = '{OP_SUB,   R_P0,    R_T,     R_P0};
      5'd27: u = '{OP_MUL30, R_K0,    R_P1,    R_T};
      5'd28: u = '{OP_SUB,   R_P1,    R_T,     R_P1};
      default: u = '{OP_ADD, R_ANGLE, R_T, R_ANGLE};
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

/* src/kaf_in_if.sv */
// Input channel of the Kalman filter: one sample per transaction.
// Depends on kaf_pkg.
`default_nettype none
interface kaf_in_if;
  logic                            valid;
  logic                            ready;
  logic                            func;
  logic signed [kaf_pkg::DATA_W-1:0] measured_angle;
  logic signed [kaf_pkg::DATA_W-1:0] gyro_rate;
  logic        [kaf_pkg::DT_W-1:0]   time_step;
  modport source (output valid, func, measured_angle, gyro_rate, time_step, input ready);
  modport sink   (input valid, func, measured_angle, gyro_rate, time_step, output ready);
endinterface
`default_nettype wire

/* src/kaf_out_if.sv */
// Result channel of the Kalman filter: one filtered angle per transaction.
// Depends on kaf_pkg.
`default_nettype none
interface kaf_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [kaf_pkg::DATA_W-1:0] filtered_angle;
  modport source (output valid, filtered_angle, input ready);
  modport sink   (input valid, filtered_angle, output ready);
endinterface
`default_nettype wire

/* src/kaf_cfg_if.sv */
// Configuration write channel of the Kalman filter.
// Depends on kaf_pkg.
`default_nettype none
interface kaf_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [kaf_pkg::IDX_W-1:0]   index;
  logic [kaf_pkg::DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/kaf_alu.sv */
// Shared arithmetic unit: saturating add and subtract, rounded fixed-point multiply
// and a restoring divider that produces one quotient bit per cycle. Depends on kaf_pkg.
`default_nettype none
module kaf_alu (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire kaf_pkg::alu_req_t        req,
  input  wire logic [kaf_pkg::DATA_W-1:0] a,
  input  wire logic [kaf_pkg::DATA_W-1:0] b,
  output logic                          done,
  output logic [kaf_pkg::DATA_W-1:0]    result
);
  import kaf_pkg::*;

  localparam int DVD_W = DATA_W + COV_FRAC;
  localparam int CNT_W = $clog2(DVD_W);

  logic [DATA_W-1:0]   ma, mb;
  logic                neg_in;
  logic [DATA_W:0]     sum, diff;
  logic [2*DATA_W-1:0] prod, rnd, mq;
  logic                neg, sh30, mul_pend, div_busy, div_fin;
  logic [DVD_W-1:0]    dvd;
  logic [DATA_W-1:0]   rem, dvs, rem_next;
  logic [DATA_W:0]     rem_sh;
  logic                ge;
  logic [CNT_W-1:0]    cnt;

  // Saturate a magnitude to the signed range and apply the sign.
  function automatic logic [DATA_W-1:0] sat_mag(input logic n, input logic [2*DATA_W-1:0] q);
    logic [2*DATA_W-1:0] lim, m;
    lim = n ? (64'd1 << (DATA_W - 1)) : ((64'd1 << (DATA_W - 1)) - 64'd1);
    m = (q > lim) ? lim : q;
    return n ? DATA_W'(-m) : m[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] sat_sum(input logic [DATA_W:0] s);
    logic [DATA_W-1:0] r;
    if (s[DATA_W] != s[DATA_W-1]) begin
      r = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r = s[DATA_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    ma     = a[DATA_W-1] ? DATA_W'(-a) : a;
    mb     = b[DATA_W-1] ? DATA_W'(-b) : b;
    neg_in = (a[DATA_W-1] ^ b[DATA_W-1]) && (a != '0) && (b != '0);
    sum    = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    diff   = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    rnd    = prod + (sh30 ? (64'd1 << (COV_FRAC - 1)) : (64'd1 << (DT_FRAC - 1)));
    mq     = sh30 ? (rnd >> COV_FRAC) : (rnd >> DT_FRAC);
    rem_sh = {rem, dvd[DVD_W-1]};
    ge     = rem_sh >= {1'b0, dvs};
    rem_next = ge ? DATA_W'(rem_sh - {1'b0, dvs}) : rem_sh[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      mul_pend <= 1'b0;
      div_busy <= 1'b0;
      div_fin  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        case (req.op)
          OP_ADD: begin
            result <= sat_sum(sum);
            done   <= 1'b1;
          end
          OP_SUB: begin
            result <= sat_sum(diff);
            done   <= 1'b1;
          end
          OP_MUL20, OP_MUL30: begin
            prod     <= ma * mb;
            neg      <= neg_in;
            sh30     <= (req.op == OP_MUL30);
            mul_pend <= 1'b1;
          end
          OP_DIV: begin
            if (mb == '0) begin
              result <= '0;
              done   <= 1'b1;
            end else begin
              dvd      <= {ma, {COV_FRAC{1'b0}}};
              rem      <= '0;
              dvs      <= mb;
              neg      <= neg_in;
              cnt      <= '0;
              div_busy <= 1'b1;
            end
          end
          default: begin
            result <= '0;
            done   <= 1'b1;
          end
        endcase
      end
      if (mul_pend) begin
        mul_pend <= 1'b0;
        result   <= sat_mag(neg, mq);
        done     <= 1'b1;
      end
      if (div_busy) begin
        rem <= rem_next;
        dvd <= {dvd[DVD_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DVD_W - 1)) begin
          div_busy <= 1'b0;
          div_fin  <= 1'b1;
        end
      end
      if (div_fin) begin
        div_fin <= 1'b0;
        result  <= sat_mag(neg, {{(2*DATA_W-DVD_W){1'b0}}, dvd});
        done    <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* src/kalman_angle_filter.sv */
// Top level of the angle and gyro-bias Kalman filter: state registers, sequencer and ports.
// Depends on kaf_pkg, kaf_in_if, kaf_out_if, kaf_cfg_if and kaf_alu.
//
//   channel   direction  carries
//   sample    in         func, measured_angle, gyro_rate, time_step
//   result    out        filtered_angle
//   cfg       in         index, data (q_angle, q_bias, meas_noise)
//
// A load-angle sample gives its result in the next cycle. An update runs 29 operations on the
// shared unit in turn: adds and subtracts register the result directly, multiplies first
// register the product, and a division develops 62 quotient bits unless the divisor is zero.
// Reset clears the estimates and the covariance and restores the default noise terms.
// The sample channel is not ready until the result transaction has completed, and is ready
// again in the cycle after it.
`default_nettype none
module kalman_angle_filter (
  input wire logic  clk,
  input wire logic  rst,
  kaf_in_if.sink    sample,
  kaf_out_if.source result,
  kaf_cfg_if.sink   cfg
);
  import kaf_pkg::*;

  state_t state, state_next;
  logic [STEP_W-1:0] step;
  logic [DATA_W-1:0] angle, bias, p0, p1, p2, p3, t, dp, tmp, s, k0, k1, y;
  logic [DATA_W-1:0] meas, gyro;
  logic [DT_W-1:0]   dt;
  logic [CFG_W-1:0]  q_angle, q_bias, meas_noise;
  uop_t              uop;
  alu_req_t          req;
  logic              alu_done;
  logic [DATA_W-1:0] alu_a, alu_b, alu_res;
  logic              in_fire;

  function automatic logic [DATA_W-1:0] pick(input opnd_t sel,
      input logic [DATA_W-1:0] va, vb, v0, v1, v2, v3, vt, vdp, vtmp, vs, vk0, vk1, vy,
      input logic [DATA_W-1:0] vm, vg, input logic [DT_W-1:0] vdt,
      input logic [CFG_W-1:0] vqa, vqb, vrm);
    logic [DATA_W-1:0] r;
    case (sel)
      R_ANGLE: r = va;
      R_BIAS:  r = vb;
      R_P0:    r = v0;
      R_P1:    r = v1;
      R_P2:    r = v2;
      R_P3:    r = v3;
      R_T:     r = vt;
      R_DP:    r = vdp;
      R_TMP:   r = vtmp;
      R_S:     r = vs;
      R_K0:    r = vk0;
      R_K1:    r = vk1;
      R_Y:     r = vy;
      R_MEAS:  r = vm;
      R_GYRO:  r = vg;
      R_DT:    r = DATA_W'(vdt);
      R_QA:    r = DATA_W'(vqa);
      R_QB:    r = DATA_W'(vqb);
      R_RM:    r = DATA_W'(vrm);
      default: r = '0;
    endcase
    return r;
  endfunction

  assign uop     = uop_rom(step);
  assign in_fire = sample.valid && sample.ready;
  assign cfg.ready = 1'b1;

  always_comb begin
    alu_a = pick(uop.a, angle, bias, p0, p1, p2, p3, t, dp, tmp, s, k0, k1, y,
                 meas, gyro, dt, q_angle, q_bias, meas_noise);
    alu_b = pick(uop.b, angle, bias, p0, p1, p2, p3, t, dp, tmp, s, k0, k1, y,
                 meas, gyro, dt, q_angle, q_bias, meas_noise);
  end

  kaf_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .a      (alu_a),
    .b      (alu_b),
    .done   (alu_done),
    .result (alu_res)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_fire) state_next = sample.func ? S_OUT : S_ISSUE;
      S_ISSUE: state_next = S_WAIT;
      S_WAIT: begin
        if (alu_done) state_next = (step == STEP_W'(NSTEPS - 1)) ? S_OUT : S_ISSUE;
      end
      S_OUT:   if (result.ready) state_next = S_IDLE;
    endcase
  end

  always_comb begin
    sample.ready = (state == S_IDLE);
    result.valid = (state == S_OUT);
    result.filtered_angle = angle;
    req.start = (state == S_ISSUE);
    req.op    = uop.op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= '0;
      angle      <= '0;
      bias       <= '0;
      p0         <= '0;
      p1         <= '0;
      p2         <= '0;
      p3         <= '0;
      q_angle    <= CFG_W'(1073742);
      q_bias     <= CFG_W'(3221225);
      meas_noise <= CFG_W'(32212255);
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        case (cfg.index)
          REG_Q_ANGLE:    q_angle    <= cfg.data[CFG_W-1:0];
          REG_Q_BIAS:     q_bias     <= cfg.data[CFG_W-1:0];
          REG_MEAS_NOISE: meas_noise <= cfg.data[CFG_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        meas <= sample.measured_angle;
        gyro <= sample.gyro_rate;
        dt   <= sample.time_step;
        step <= '0;
        if (sample.func) angle <= sample.measured_angle;
      end
      if (state == S_WAIT && alu_done) begin
        step <= step + 1'b1;
        case (uop.dst)
          R_ANGLE: angle <= alu_res;
          R_BIAS:  bias  <= alu_res;
          R_P0:    p0    <= alu_res;
          R_P1:    p1    <= alu_res;
          R_P2:    p2    <= alu_res;
          R_P3:    p3    <= alu_res;
          R_T:     t     <= alu_res;
          R_DP:    dp    <= alu_res;
          R_TMP:   tmp   <= alu_res;
          R_S:     s     <= alu_res;
          R_K0:    k0    <= alu_res;
          R_K1:    k1    <= alu_res;
          R_Y:     y     <= alu_res;
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for the angle and gyro-bias Kalman filter.
// Directed and random samples: each result is compared with a known or fixed-point predicted value.
// Depends on kaf_pkg, kaf_in_if, kaf_out_if, kaf_cfg_if and kalman_angle_filter.
`default_nettype none
module tb_top;
  import kaf_pkg::*;

  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_LOAD   = 1'b1;
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam longint CYCLE_LIMIT = 2_000_000;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic        func;
    logic [31:0] meas;
    logic [31:0] gyro;
    logic [23:0] dt;
    bit          known;
    logic [31:0] angle;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  longint cycles = 0;
  int errors = 0;
  bit quiet_rx = 1'b0;
  bit long_hold = 1'b0;

  kaf_in_if  sample ();
  kaf_out_if result ();
  kaf_cfg_if cfg ();

  kalman_angle_filter dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .result (result),
    .cfg    (cfg)
  );

  // Predictor state, all values held within the signed 32-bit range.
  longint est_angle, est_bias;
  longint cov [4];
  longint noise_qa, noise_qb, noise_r;
  logic [31:0] angle_q [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic longint clamp32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // Rounded, saturating product: magnitudes multiplied exactly, half away from zero.
  function automatic longint fx_mul(input longint a, input longint b, input int sh);
    logic [127:0] p;
    logic [127:0] lim;
    bit neg;
    longint ma, mb;
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    neg = ((a < 0) != (b < 0)) && a != 0 && b != 0;
    p   = {64'd0, ma} * {64'd0, mb};
    p   = (p + (128'd1 << (sh - 1))) >> sh;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (p > lim) p = lim;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint fx_div(input longint num, input longint den);
    logic [127:0] q;
    logic [127:0] lim;
    bit neg;
    longint mn, md;
    mn = (num < 0) ? -num : num;
    md = (den < 0) ? -den : den;
    if (md == 0) return 0;
    q   = ({64'd0, mn} << COV_FRAC) / {64'd0, md};
    neg = ((num < 0) != (den < 0)) && q != 0;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) q = lim;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic logic [31:0] filter_step(input logic func, input logic [31:0] meas_bits,
                                              input logic [31:0] gyro_bits,
                                              input logic [23:0] dt_bits);
    longint meas, gyro, dt, rate, dp, tmp, s, k0, k1, y, p00, p01;
    meas = longint'($signed(meas_bits));
    gyro = longint'($signed(gyro_bits));
    dt   = longint'(dt_bits);
    if (func == FUNC_LOAD) begin
      est_angle = meas;
    end else begin
      rate      = clamp32(gyro - est_bias);
      est_angle = clamp32(est_angle + fx_mul(dt, rate, DT_FRAC));
      dp        = fx_mul(dt, cov[3], DT_FRAC);
      tmp       = clamp32(clamp32(clamp32(dp - cov[1]) - cov[2]) + noise_qa);
      cov[0]    = clamp32(cov[0] + fx_mul(dt, tmp, DT_FRAC));
      cov[1]    = clamp32(cov[1] - dp);
      cov[2]    = clamp32(cov[2] - dp);
      cov[3]    = clamp32(cov[3] + fx_mul(noise_qb, dt, DT_FRAC));
      s         = clamp32(cov[0] + noise_r);
      k0        = fx_div(cov[0], s);
      k1        = fx_div(cov[2], s);
      y         = clamp32(meas - est_angle);
      est_angle = clamp32(est_angle + fx_mul(k0, y, COV_FRAC));
      est_bias  = clamp32(est_bias + fx_mul(k1, y, COV_FRAC));
      p00       = cov[0];
      p01       = cov[1];
      cov[0]    = clamp32(cov[0] - fx_mul(k0, p00, COV_FRAC));
      cov[1]    = clamp32(cov[1] - fx_mul(k0, p01, COV_FRAC));
      cov[2]    = clamp32(cov[2] - fx_mul(k1, p00, COV_FRAC));
      cov[3]    = clamp32(cov[3] - fx_mul(k1, p01, COV_FRAC));
    end
    return est_angle[31:0];
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      REG_Q_ANGLE:    noise_qa = longint'(value[CFG_W-1:0]);
      REG_Q_BIAS:     noise_qb = longint'(value[CFG_W-1:0]);
      REG_MEAS_NOISE: noise_r  = longint'(value[CFG_W-1:0]);
      default: ;
    endcase
    // Valid goes low between writes, keeping the next write's valid apart from this one.
    @(posedge clk);
  endtask

  task automatic send_sample(input sample_row_t row, input bit no_gap);
    int gap;
    logic [31:0] predicted;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      sample.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample.valid          <= 1'b1;
    sample.func           <= row.func;
    sample.measured_angle <= row.meas;
    sample.gyro_rate      <= row.gyro;
    sample.time_step      <= row.dt;
    do @(posedge clk); while (!sample.ready);
    predicted = filter_step(row.func, row.meas, row.gyro, row.dt);
    angle_q.push_back(row.known ? row.angle : predicted);
  endtask

  task automatic wait_drained();
    sample.valid <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 360 << 16)) - (180 << 16));
    endcase
  endfunction

  function automatic sample_row_t rand_row();
    sample_row_t r;
    r.func  = ($urandom_range(0, 19) == 0) ? FUNC_LOAD : FUNC_UPDATE;
    r.meas  = rand_q16();
    r.gyro  = rand_q16();
    r.dt    = ($urandom_range(0, 7) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 40000));
    r.known = 1'b0;
    r.angle = '0;
    return r;
  endfunction

  // Receiver: random stalls, an optional quiet phase and one long hold-off.
  initial begin
    int n;
    result.ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (long_hold) begin
        n = 400;
        long_hold = 1'b0;
      end else begin
        n = quiet_rx ? 0 : $urandom_range(0, 6);
      end
      if (n > 0) begin
        result.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!result.valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      if (angle_q.size() == 0) begin
        $display("%0t: unexpected result transaction, filtered_angle %h", $time,
                 result.filtered_angle);
        errors++;
      end else if (result.filtered_angle !== angle_q[0]) begin
        $display("%0t: filtered_angle expected %h actual %h", $time, angle_q[0],
                 result.filtered_angle);
        errors++;
        void'(angle_q.pop_front());
      end else begin
        void'(angle_q.pop_front());
      end
    end
  end

  initial begin
    sample_row_t directed [$];
    sample_row_t row;
    logic [31:0] cfg_sets [5][3];
    sample.valid = 1'b0;
    sample.func = FUNC_UPDATE;
    sample.measured_angle = '0;
    sample.gyro_rate = '0;
    sample.time_step = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_Q_ANGLE;
    cfg.data = '0;
    est_angle = 0;
    est_bias = 0;
    foreach (cov[i]) cov[i] = 0;
    noise_qa = 1073742;
    noise_qb = 3221225;
    noise_r  = 32212255;

    // Known results: direct loads of extreme angles, and updates with a zero time step
    // from zero covariance, where the gain is zero and the angle is held.
    directed = '{
      '{FUNC_UPDATE, 32'h0000_0000, 32'h0000_0000, 24'h000000, 1'b1, 32'h0000_0000},
      '{FUNC_LOAD,   32'h7FFF_FFFF, 32'h8000_0000, 24'hFFFFFF, 1'b1, 32'h7FFF_FFFF},
      '{FUNC_UPDATE, 32'h7FFF_FFFF, 32'h0000_0000, 24'h000000, 1'b1, 32'h7FFF_FFFF},
      '{FUNC_LOAD,   32'h8000_0000, 32'h7FFF_FFFF, 24'h000000, 1'b1, 32'h8000_0000},
      '{FUNC_LOAD,   32'h0000_0000, 32'h0000_0000, 24'h000000, 1'b1, 32'h0000_0000},
      '{FUNC_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFFFFFF, 1'b0, 32'h0},
      '{FUNC_UPDATE, 32'h8000_0000, 32'h8000_0000, 24'hFFFFFF, 1'b0, 32'h0},
      '{FUNC_UPDATE, 32'h0000_0000, 32'h7FFF_FFFF, 24'h000001, 1'b0, 32'h0},
      '{FUNC_UPDATE, 32'h0014_0000, 32'h0002_0000, 24'h002800, 1'b0, 32'h0},
      '{FUNC_UPDATE, 32'hFFEC_0000, 32'hFFFE_0000, 24'h002800, 1'b0, 32'h0},
      '{FUNC_UPDATE, 32'h5A00_0000, 32'hA600_0000, 24'h100000, 1'b0, 32'h0},
      '{FUNC_LOAD,   32'hFF4C_0000, 32'h0000_0000, 24'h000000, 1'b0, 32'h0},
      '{FUNC_UPDATE, 32'h00B4_0000, 32'h0000_0000, 24'h800000, 1'b0, 32'h0},
      '{FUNC_UPDATE, 32'h0000_0001, 32'hFFFF_FFFF, 24'h7FFFFF, 1'b0, 32'h0},
      '{FUNC_UPDATE, 32'hFFFF_FFFF, 32'h0000_0001, 24'h000000, 1'b0, 32'h0}
    };

    // Noise settings per phase: reset values, minima, maxima with unused upper bits set,
    // and two random mixes.
    cfg_sets = '{
      '{32'd1073742,     32'd3221225,     32'd32212255},
      '{32'h0000_0000,   32'h0000_0000,   32'h0000_0001},
      '{32'hFFFF_FFFF,   32'hFFFF_FFFF,   32'hFFFF_FFFF},
      '{$urandom(),      $urandom(),      $urandom_range(1, 32'h3FFF_FFFF)},
      '{$urandom_range(0, 1 << 22), $urandom_range(0, 1 << 22), $urandom_range(1, 1 << 26)}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_sample(directed[i], 1'b0);
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_Q_ANGLE, cfg_sets[ph][0]);
      write_reg(REG_Q_BIAS, cfg_sets[ph][1]);
      write_reg(REG_MEAS_NOISE, cfg_sets[ph][2]);
      if (ph == 3) write_reg(REG_UNUSED, $urandom());
      quiet_rx = (ph == 1);
      for (int i = 0; i < 307; i++) begin
        if (ph == 2 && i == 100) long_hold = 1'b1;
        row = rand_row();
        send_sample(row, (ph == 1));
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && angle_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* kalman_angle_filter.f */
src/kaf_pkg.sv
src/kaf_in_if.sv
src/kaf_out_if.sv
src/kaf_cfg_if.sv
src/kaf_alu.sv
src/kalman_angle_filter.sv
tb/sv/tb_top.sv
